// ===== rtl/ta2_pkg.sv =====
// Shared constants, types and the arctangent table builder for the atan2 unit.
// No dependencies; every other file in rtl/ imports this package.
package ta2_pkg;

  // Coordinate and magnitude widths.
  localparam int XY_W  = 32;
  localparam int MAG_W = 32;

  // Ratio z = min/max in Q1.24: it can reach 1.0, so one extra bit above the 24 fraction bits.
  localparam int FRAC_BITS = 24;
  localparam int Z_W       = FRAC_BITS + 1;
  localparam int DIV_STAGES = Z_W;

  // Arctangent table geometry.
  localparam int TABLE_STEPS = 256;
  localparam int IDX_W       = $clog2(TABLE_STEPS);
  localparam int TIDX_W      = $clog2(TABLE_STEPS + 1);
  localparam int MUL_W       = Z_W + TIDX_W;

  // Ratios with z * (TABLE_STEPS - 1) below one use z itself as the angle.
  localparam int SMALL_LIM = (2 ** FRAC_BITS + TABLE_STEPS - 2) / (TABLE_STEPS - 1);
  localparam int HALF_STEP = 2 ** (FRAC_BITS - 1);

  // Angle formats: the table and base angle are Q3.29 values up to pi/4.
  localparam int Q_SHIFT = 29 - FRAC_BITS;
  localparam int ROM_W   = 30;
  localparam int BASE_W  = ROM_W;
  localparam int DIFF_W  = ROM_W + 1;
  localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W   = PROD_W - FRAC_BITS;
  localparam int ANG_W   = 35;
  localparam int OUT_W   = 33;

  localparam logic signed [ANG_W-1:0] PI_Q29      = ANG_W'(64'sd1686629713);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q29 = ANG_W'(64'sd843314857);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q29  = ANG_W'(64'sd3373259426);

  // Octant information that travels alongside the ratio.
  typedef struct packed {
    logic zero;   // both coordinates are zero
    logic x_neg;
    logic y_neg;
    logic x_gt;   // |x| > |y|
  } oct_t;

  // CORDIC micro-rotation angles in Q2.30, used only to build the table.
  localparam int CORDIC_STEPS = 31;
  localparam longint CORDIC_ANGLE [CORDIC_STEPS] = '{
    843314856, 497837829, 263043836, 133525158, 67021687,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63,
    31, 15, 8, 4, 2, 1
  };

  // Table entry k holds atan(k / (TABLE_STEPS - 1)) in Q3.29; the last entry
  // repeats the one before it. Evaluated at elaboration only.
  function automatic logic [ROM_W-1:0] atan_entry(input int k);
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint acc;
    int     kk;
    kk  = (k >= TABLE_STEPS) ? TABLE_STEPS - 1 : k;
    cx  = longint'(TABLE_STEPS - 1) <<< 32;
    cy  = longint'(kk) <<< 32;
    acc = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        acc = acc + CORDIC_ANGLE[i];
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        acc = acc - CORDIC_ANGLE[i];
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (kk == 0) begin
      acc = 0;
    end
    return ROM_W'((acc + 1) >>> 1);
  endfunction

endpackage

// ===== rtl/ta2_prep.sv =====
// Front end of the atan2 pipeline: magnitudes, octant flags, min/max select.
// Depends on ta2_pkg.
module ta2_prep
  import ta2_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [XY_W-1:0]  x_coord,
  input  logic [XY_W-1:0]  y_coord,
  output logic             out_valid,
  output logic [MAG_W-1:0] lo_mag,
  output logic [MAG_W-1:0] hi_mag,
  output oct_t             oct
);

  logic [1:0]       v_r;
  logic [MAG_W-1:0] xa_r;
  logic [MAG_W-1:0] ya_r;
  logic             xn_r;
  logic             yn_r;
  logic             zero_r;
  logic [MAG_W-1:0] lo_r;
  logic [MAG_W-1:0] hi_r;
  oct_t             oct_r;
  logic             x_gt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[0], in_valid};
    end
  end

  // The most negative input maps to 2^31, which still fits as unsigned.
  always_ff @(posedge clk) begin
    if (adv) begin
      xa_r   <= x_coord[XY_W-1] ? (~x_coord + 1'b1) : x_coord;
      ya_r   <= y_coord[XY_W-1] ? (~y_coord + 1'b1) : y_coord;
      xn_r   <= x_coord[XY_W-1];
      yn_r   <= y_coord[XY_W-1];
      zero_r <= (x_coord == '0) && (y_coord == '0);
    end
  end

  assign x_gt = xa_r > ya_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r        <= x_gt ? ya_r : xa_r;
      hi_r        <= x_gt ? xa_r : ya_r;
      oct_r.zero  <= zero_r;
      oct_r.x_neg <= xn_r;
      oct_r.y_neg <= yn_r;
      oct_r.x_gt  <= x_gt;
    end
  end

  assign out_valid = v_r[1];
  assign lo_mag    = lo_r;
  assign hi_mag    = hi_r;
  assign oct       = oct_r;

endmodule

// ===== rtl/ta2_div.sv =====
// Pipelined restoring divider producing z = floor(lo * 2^24 / hi), one
// quotient bit per stage. Depends on ta2_pkg.
module ta2_div
  import ta2_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [MAG_W-1:0] lo_mag,
  input  logic [MAG_W-1:0] hi_mag,
  input  oct_t             in_oct,
  output logic             out_valid,
  output logic [Z_W-1:0]   z,
  output oct_t             out_oct
);

  logic [DIV_STAGES-1:0] v_r;
  logic [MAG_W-1:0]      rem_r   [DIV_STAGES];
  logic [MAG_W-1:0]      hi_r    [DIV_STAGES];
  logic [Z_W-1:0]        quo_r   [DIV_STAGES];
  oct_t                  oct_r   [DIV_STAGES];
  logic [MAG_W-1:0]      rem_nxt [DIV_STAGES];
  logic [Z_W-1:0]        quo_nxt [DIV_STAGES];

  // Since lo <= hi, the integer bit is set only for equal magnitudes. Each
  // later stage doubles the remainder and tries one subtraction.
  always_comb begin
    logic [MAG_W:0] t;
    logic [MAG_W:0] d;
    logic           ge;
    ge         = lo_mag >= hi_mag;
    d          = {1'b0, lo_mag} - {1'b0, hi_mag};
    rem_nxt[0] = ge ? d[MAG_W-1:0] : lo_mag;
    quo_nxt[0] = Z_W'(ge);
    for (int k = 1; k < DIV_STAGES; k++) begin
      t          = {rem_r[k-1], 1'b0};
      d          = t - {1'b0, hi_r[k-1]};
      ge         = t >= {1'b0, hi_r[k-1]};
      rem_nxt[k] = ge ? d[MAG_W-1:0] : t[MAG_W-1:0];
      quo_nxt[k] = {quo_r[k-1][Z_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= rem_nxt[0];
      quo_r[0] <= quo_nxt[0];
      hi_r[0]  <= hi_mag;
      oct_r[0] <= in_oct;
      for (int k = 1; k < DIV_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        hi_r[k]  <= hi_r[k-1];
        oct_r[k] <= oct_r[k-1];
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign z         = quo_r[DIV_STAGES-1];
  assign out_oct   = oct_r[DIV_STAGES-1];

endmodule

// ===== rtl/ta2_interp.sv =====
// Table lookup, linear interpolation and octant mapping for the atan2 unit.
// Depends on ta2_pkg (table builder, constants, oct_t).
module ta2_interp
  import ta2_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             mode,
  input  logic             in_valid,
  input  logic [Z_W-1:0]   z,
  input  oct_t             in_oct,
  output logic             out_valid,
  output logic [OUT_W-1:0] angle
);

  localparam logic [MUL_W-1:0] STEPS_M = MUL_W'(TABLE_STEPS);
  localparam logic [MUL_W-1:0] HALF_M  = MUL_W'(HALF_STEP);
  localparam logic [Z_W-1:0]   LIM_Z   = Z_W'(SMALL_LIM);

  logic [ROM_W-1:0] rom_tbl [TABLE_STEPS+1];

  for (genvar g = 0; g <= TABLE_STEPS; g++) begin : g_rom
    assign rom_tbl[g] = atan_entry(g);
  end

  logic [4:0] v_r;

  logic [IDX_W-1:0]         s1_idx_r;
  logic [FRAC_BITS-1:0]     s1_f_r;
  logic                     s1_small_r;
  logic [BASE_W-1:0]        s1_sbase_r;
  oct_t                     s1_oct_r;

  logic [ROM_W-1:0]         s2_lo_r;
  logic signed [DIFF_W-1:0] s2_diff_r;
  logic [FRAC_BITS-1:0]     s2_f_r;
  logic                     s2_small_r;
  logic [BASE_W-1:0]        s2_sbase_r;
  oct_t                     s2_oct_r;

  logic [ROM_W-1:0]         s3_lo_r;
  logic signed [PROD_W-1:0] s3_prod_r;
  logic                     s3_small_r;
  logic [BASE_W-1:0]        s3_sbase_r;
  oct_t                     s3_oct_r;

  logic [BASE_W-1:0]        s4_base_r;
  oct_t                     s4_oct_r;

  logic signed [ANG_W-1:0]  s5_angle_r;

  logic [MUL_W-1:0]         pos;
  logic [TIDX_W-1:0]        rd_lo;
  logic [TIDX_W-1:0]        rd_hi;
  logic [SUM_W-1:0]         isum;
  logic signed [ANG_W-1:0]  base_ext;
  logic signed [ANG_W-1:0]  corner;
  logic signed [ANG_W-1:0]  ang;
  logic signed [ANG_W-1:0]  wrapped;
  logic                     sub_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // Table position: z * steps - 1/2, split into entry index and fraction.
  assign pos = MUL_W'(z) * STEPS_M - HALF_M;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r   <= pos[FRAC_BITS +: IDX_W];
      s1_f_r     <= pos[FRAC_BITS-1:0];
      s1_small_r <= z < LIM_Z;
      s1_sbase_r <= BASE_W'({z, {Q_SHIFT{1'b0}}});
      s1_oct_r   <= in_oct;
    end
  end

  assign rd_lo = TIDX_W'(s1_idx_r);
  assign rd_hi = TIDX_W'(s1_idx_r) + 1'b1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_lo_r    <= rom_tbl[rd_lo];
      s2_diff_r  <= signed'({1'b0, rom_tbl[rd_hi]}) - signed'({1'b0, rom_tbl[rd_lo]});
      s2_f_r     <= s1_f_r;
      s2_small_r <= s1_small_r;
      s2_sbase_r <= s1_sbase_r;
      s2_oct_r   <= s1_oct_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_lo_r    <= s2_lo_r;
      s3_prod_r  <= s2_diff_r * signed'({1'b0, s2_f_r});
      s3_small_r <= s2_small_r;
      s3_sbase_r <= s2_sbase_r;
      s3_oct_r   <= s2_oct_r;
    end
  end

  // Dropping the low fraction bits of the signed product is a floor shift.
  assign isum = SUM_W'(s3_lo_r) + s3_prod_r[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_base_r <= s3_small_r ? s3_sbase_r : isum[BASE_W-1:0];
      s4_oct_r  <= s3_oct_r;
    end
  end

  // Octant mapping: angle = corner +/- base.
  assign base_ext = ANG_W'(s4_base_r);

  always_comb begin
    if (s4_oct_r.x_gt) begin
      if (!s4_oct_r.x_neg) begin
        corner   = '0;
        sub_base = s4_oct_r.y_neg;
      end else begin
        corner   = s4_oct_r.y_neg ? -PI_Q29 : PI_Q29;
        sub_base = !s4_oct_r.y_neg;
      end
    end else begin
      corner   = s4_oct_r.y_neg ? -HALF_PI_Q29 : HALF_PI_Q29;
      sub_base = s4_oct_r.x_neg == s4_oct_r.y_neg;
    end
  end

  assign ang = corner + (sub_base ? -base_ext : base_ext);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_angle_r <= s4_oct_r.zero ? '0 : ang;
    end
  end

  assign wrapped   = (mode && s5_angle_r[ANG_W-1]) ? s5_angle_r + TWO_PI_Q29 : s5_angle_r;
  assign out_valid = v_r[4];
  assign angle     = wrapped[OUT_W-1:0];

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline valid bits moved while the pipeline was held");

  a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && !s4_oct_r.zero) |-> (s4_base_r <= rom_tbl[TABLE_STEPS]))
    else $error("interpolated base angle exceeds pi/4");

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v_r[3] && s4_oct_r.zero) |=> (s5_angle_r == '0))
    else $error("zero input did not give a zero angle");
`endif

endmodule

// ===== rtl/ta2_obuf.sv =====
// Two-entry output buffer (result register plus skid register) for the atan2
// unit; its fill state produces the pipeline advance. Depends on ta2_pkg.
module ta2_obuf
  import ta2_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [OUT_W-1:0] push_data,
  output logic             adv,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_data,
  input  logic             out_stall
);

  logic             main_full_r;
  logic             skid_full_r;
  logic [OUT_W-1:0] main_r;
  logic [OUT_W-1:0] skid_r;
  logic             main_full_nxt;
  logic             skid_full_nxt;
  logic             pop;
  logic             push;

  assign adv  = !skid_full_r;
  assign pop  = main_full_r && !out_stall;
  assign push = push_valid && !skid_full_r;

  always_comb begin
    main_full_nxt = main_full_r;
    skid_full_nxt = skid_full_r;
    if (skid_full_r) begin
      if (pop) begin
        skid_full_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_full_r && !pop) begin
        skid_full_nxt = 1'b1;
      end else begin
        main_full_nxt = 1'b1;
      end
    end else if (pop) begin
      main_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_full_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      main_full_r <= main_full_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_full_r && !pop) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

  assign out_valid = main_full_r;
  assign out_data  = main_r;

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> main_full_r)
    else $error("skid register holds an item while the result register is empty");

  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (push && main_full_r && out_stall) |=> skid_full_r)
    else $error("item arriving under a stalled output was not captured");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_full_r && !out_stall) |=> (main_full_r && !skid_full_r))
    else $error("skid register did not drain into the result register");
`endif

endmodule

// ===== rtl/table_atan2_interpolated_unit.sv =====
// Top level of the table-based four-quadrant arctangent unit.
// Depends on ta2_pkg, ta2_prep, ta2_div, ta2_interp and ta2_obuf.
// - Input channel (in_valid / in_stall) carries one item: a signed 32-bit
//   coordinate pair in_x_coord, in_y_coord. An item is taken at a rising
//   edge where in_valid is high and in_stall is low.
// - Result channel (out_valid / out_stall) returns one item per input item,
//   out_theta, the angle in signed Q3.29 radians, in input order.
// - Configuration channel (cfg_valid / cfg_ready) writes the single mode
//   bit cfg_positive_range_mode; cfg_ready is always high. With the bit set,
//   negative angles are moved up by two pi into the range 0 to 2pi. Write it
//   only while no item is in flight.
// - One item is accepted per cycle while in_stall is low. From the accepting
//   edge to out_valid an item passes through the two front-end stages, the
//   25-stage bit-per-stage divider, five table/interpolation stages and the
//   result register.
// - When the receiver stalls, the pipeline keeps running until the skid
//   register behind the result register fills; in_stall then rises and the
//   whole pipeline holds, losing nothing. in_stall comes from a register.
// - Synchronous active-low reset empties the pipeline and clears the mode
//   bit; the arctangent table is constant and needs no initialization.
module table_atan2_interpolated_unit
  import ta2_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [XY_W-1:0]  in_x_coord,
  input  logic [XY_W-1:0]  in_y_coord,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_theta,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_positive_range_mode
);

  logic             adv;
  logic             mode_r;

  logic             prep_valid;
  logic [MAG_W-1:0] prep_lo;
  logic [MAG_W-1:0] prep_hi;
  oct_t             prep_oct;

  logic             div_valid;
  logic [Z_W-1:0]   div_z;
  oct_t             div_oct;

  logic             ang_valid;
  logic [OUT_W-1:0] ang_data;

  // The mode register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_positive_range_mode;
    end
  end

  // Every pipeline stage moves together whenever the output buffer has room.
  assign in_stall = !adv;

  ta2_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .x_coord   (in_x_coord),
    .y_coord   (in_y_coord),
    .out_valid (prep_valid),
    .lo_mag    (prep_lo),
    .hi_mag    (prep_hi),
    .oct       (prep_oct)
  );

  ta2_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (prep_valid),
    .lo_mag    (prep_lo),
    .hi_mag    (prep_hi),
    .in_oct    (prep_oct),
    .out_valid (div_valid),
    .z         (div_z),
    .out_oct   (div_oct)
  );

  ta2_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .mode      (mode_r),
    .in_valid  (div_valid),
    .z         (div_z),
    .in_oct    (div_oct),
    .out_valid (ang_valid),
    .angle     (ang_data)
  );

  ta2_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (ang_valid),
    .push_data  (ang_data),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_data   (out_theta),
    .out_stall  (out_stall)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for table_atan2_interpolated_unit (four-quadrant atan2 in Q3.29).
// Depends on ta2_pkg for port widths and angle constants, and on the RTL top level.
module testbench
  import ta2_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Run control.
  localparam int RESET_CYCLES = 11;
  localparam int LONG_HOLD    = 300;     // receiver hold-off that fills the pipeline
  localparam int DRAIN_CYCLES = 40;      // a little more than the pipeline latency
  localparam int CYCLE_LIMIT  = 400000;  // generous bound on the whole run

  localparam logic [XY_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [XY_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [XY_W-1:0] COORD_M1  = 32'hFFFF_FFFF;

  // One pending input item. When hold_for_drain is set, the driver keeps the
  // channel quiet until every result in flight has come back.
  typedef struct {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    bit              hold_for_drain;
  } coord_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [XY_W-1:0]  in_x_coord = '0;
  logic [XY_W-1:0]  in_y_coord = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] out_theta;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_positive_range_mode = 1'b0;

  // Arctangent table rebuilt here from the integer CORDIC definition.
  longint           atan_table [TABLE_STEPS+1];

  coord_item_t      coord_pending[$];   // items the driver has yet to offer
  logic [OUT_W-1:0] angle_expect[$];    // predicted angles of accepted items
  logic [OUT_W-1:0] expected_angle;
  bit               range_mode_model = 1'b0;
  bit               in_taken = 1'b0;    // set at the edge that accepted an item
  bit               calm = 1'b0;        // no idling on either side once set
  bit               hold_armed = 1'b0;
  int               send_gap = 0;
  int               stall_left = 0;
  int               hold_left = -1;     // -1 until the long hold has started
  int               fail_count = 0;
  int               cycle_count = 0;

  table_atan2_interpolated_unit dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_x_coord              (in_x_coord),
    .in_y_coord              (in_y_coord),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_theta               (out_theta),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_positive_range_mode (cfg_positive_range_mode)
  );

  always #1 clk = ~clk;

  // Table entry k is atan(k / (TABLE_STEPS - 1)) by a 31-step CORDIC in
  // Q2.30, clamped at zero and rounded half up to Q3.29. The arithmetic
  // shifts on longint round toward minus infinity, as the definition needs.
  function automatic longint cordic_atan(input int k);
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint acc;
    cx  = longint'(TABLE_STEPS - 1) <<< 32;
    cy  = longint'(k) <<< 32;
    acc = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        acc = acc + CORDIC_ANGLE[i];
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        acc = acc - CORDIC_ANGLE[i];
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return (acc + 1) >>> 1;
  endfunction

  // Expected angle of one coordinate pair under the given range mode.
  function automatic logic [OUT_W-1:0] predict_angle(input logic [XY_W-1:0] xc,
                                                     input logic [XY_W-1:0] yc,
                                                     input bit pos_mode);
    longint x;
    longint y;
    longint xa;
    longint ya;
    longint lo;
    longint hi;
    longint z;
    longint a;
    longint idx;
    longint frac;
    longint base;
    longint angle;
    x = $signed(xc);
    y = $signed(yc);
    if (x == 0 && y == 0) begin
      return '0;
    end
    // The most negative coordinate has magnitude 2^31, exactly, in 64 bits.
    xa = (x < 0) ? -x : x;
    ya = (y < 0) ? -y : y;
    lo = (ya < xa) ? ya : xa;
    hi = (ya < xa) ? xa : ya;
    z  = (lo <<< FRAC_BITS) / hi;
    if (z * (TABLE_STEPS - 1) < (longint'(1) <<< FRAC_BITS)) begin
      // Small ratios stand for their own angle.
      base = z <<< (29 - FRAC_BITS);
    end else begin
      a    = z * TABLE_STEPS - (longint'(1) <<< (FRAC_BITS - 1));
      idx  = a >>> FRAC_BITS;
      frac = a & ((longint'(1) <<< FRAC_BITS) - 1);
      if (idx > TABLE_STEPS - 1) begin
        idx = TABLE_STEPS - 1;
      end
      base = atan_table[idx] +
             (((atan_table[idx+1] - atan_table[idx]) * frac) >>> FRAC_BITS);
    end
    // Place the base angle in its octant; ties go to the vertical branch.
    if (xa > ya) begin
      if (x >= 0) begin
        angle = (y >= 0) ? base : -base;
      end else begin
        angle = (y >= 0) ? longint'(PI_Q29) - base : base - longint'(PI_Q29);
      end
    end else begin
      if (y >= 0) begin
        angle = (x >= 0) ? longint'(HALF_PI_Q29) - base : longint'(HALF_PI_Q29) + base;
      end else begin
        angle = (x >= 0) ? base - longint'(HALF_PI_Q29) : -longint'(HALF_PI_Q29) - base;
      end
    end
    if (pos_mode && angle < 0) begin
      angle = angle + longint'(TWO_PI_Q29);
    end
    return angle[OUT_W-1:0];
  endfunction

  // Random magnitude spread over all scales, with a random sign.
  function automatic logic [XY_W-1:0] scaled_coord();
    logic [XY_W-1:0] v;
    v = $urandom >> $urandom_range(1, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [XY_W-1:0] extreme_coord();
    case ($urandom_range(0, 4))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return 32'd1;
      default: return COORD_M1;
    endcase
  endfunction

  task automatic queue_coord(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                             input bit hold_for_drain);
    coord_item_t item;
    item.x = x;
    item.y = y;
    item.hold_for_drain = hold_for_drain;
    coord_pending.push_back(item);
  endtask

  // Extremes of both fields, every octant but |x| > |y| with x and y negative, both sides
  // of the small-ratio threshold, equal magnitudes and the most negative coordinate.
  task automatic queue_directed();
    queue_coord(32'd0, 32'd0, 1'b0);
    queue_coord(32'd1, 32'd0, 1'b0);
    queue_coord(32'd0, 32'd1, 1'b0);
    queue_coord(COORD_M1, 32'd0, 1'b0);
    queue_coord(32'd0, COORD_M1, 1'b0);
    queue_coord(COORD_MAX, 32'd0, 1'b0);
    queue_coord(COORD_MIN, 32'd0, 1'b0);
    queue_coord(32'd0, COORD_MIN, 1'b0);
    queue_coord(COORD_MAX, COORD_MAX, 1'b0);
    queue_coord(COORD_MIN, COORD_MIN, 1'b0);
    queue_coord(COORD_MIN, COORD_MAX, 1'b0);
    queue_coord(COORD_MAX, COORD_MIN, 1'b0);
    queue_coord(32'd5, -32'd5, 1'b0);
    queue_coord(-32'd7, 32'd7, 1'b0);
    queue_coord(32'd255, 32'd1, 1'b0);
    queue_coord(32'd254, -32'd1, 1'b0);
    queue_coord(-32'd1, 32'd255, 1'b0);
    queue_coord(32'd1, -32'd254, 1'b0);
    queue_coord(COORD_MAX, 32'd1, 1'b0);
    queue_coord(COORD_M1, COORD_MIN, 1'b0);
    queue_coord(32'd1000, 32'd999, 1'b0);
    queue_coord(-32'd999, -32'd1000, 1'b0);
    queue_coord(-32'd3, 32'd1, 1'b0);
    queue_coord(32'd2, -32'd3, 1'b0);
  endtask

  // Random pairs of several shapes. The item at position drain_at, if any,
  // waits for the pipeline to empty before it is offered.
  task automatic queue_random(input int count, input int drain_at);
    logic [XY_W-1:0] xv;
    logic [XY_W-1:0] yv;
    logic [XY_W-1:0] hi;
    logic [XY_W-1:0] lo;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          xv = $urandom;
          yv = $urandom;
        end
        3: begin
          xv = scaled_coord();
          yv = scaled_coord();
        end
        4: begin
          // Close to a diagonal, where the table index reaches its top.
          xv = scaled_coord();
          yv = xv + $urandom_range(0, 8) - 4;
          if ($urandom_range(0, 1)) begin
            yv = -yv;
          end
        end
        5: begin
          xv = $urandom_range(0, 1) ? $urandom : scaled_coord();
          yv = '0;
          if ($urandom_range(0, 1)) begin
            yv = xv;
            xv = '0;
          end
        end
        6: begin
          // Around the ratio where the direct angle gives way to the table.
          hi = $urandom_range(255, 32'h7FFF_FFFF);
          lo = hi / 255 + $urandom_range(0, 2) - 1;
          xv = $urandom_range(0, 1) ? -hi : hi;
          yv = $urandom_range(0, 1) ? -lo : lo;
          if ($urandom_range(0, 1)) begin
            hi = xv;
            xv = yv;
            yv = hi;
          end
        end
        default: begin
          xv = extreme_coord();
          yv = $urandom_range(0, 1) ? extreme_coord() : $urandom;
        end
      endcase
      queue_coord(xv, yv, n == drain_at);
    end
  endtask

  // The mode bit is only written with nothing in flight.
  task automatic write_mode(input bit mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_positive_range_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    range_mode_model = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every pending item has been taken and every result returned.
  task automatic wait_idle();
    while (coord_pending.size() != 0 || in_valid || angle_expect.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: offers the next pending item at the falling edge. A payload that
  // has not been taken yet stays put; after a taken item the sender may go
  // quiet for a short burst.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (coord_pending.size() != 0 &&
                     !(coord_pending[0].hold_for_drain && angle_expect.size() != 0)) begin
          in_valid   <= 1'b1;
          in_x_coord <= coord_pending[0].x;
          in_y_coord <= coord_pending[0].y;
          void'(coord_pending.pop_front());
          if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // Receiver stall: one long hold-off once armed, otherwise random bursts.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_armed && hold_left < 0) begin
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts each accepted item and checks each accepted result
  // against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        angle_expect.push_back(predict_angle(in_x_coord, in_y_coord, range_mode_model));
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (angle_expect.size() == 0) begin
          $error("out_theta: no item expected, got %0d", $signed(out_theta));
          fail_count++;
        end else begin
          expected_angle = angle_expect.pop_front();
          if (out_theta !== expected_angle) begin
            $error("out_theta: expected %0d, got %0d",
                   $signed(expected_angle), $signed(out_theta));
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on the total number of cycles.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("table_atan2_interpolated_unit test failed");
    $finish;
  end

  // Sequence of the run: directed items in both modes, then random phases
  // with the mode switched between them, the long receiver hold in the
  // first random phase, and a final phase without any idling.
  initial begin
    atan_table[0] = 0;
    for (int k = 1; k < TABLE_STEPS; k++) begin
      atan_table[k] = cordic_atan(k);
    end
    atan_table[TABLE_STEPS] = atan_table[TABLE_STEPS-1];

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mode(1'b0);
    queue_directed();
    wait_idle();

    write_mode(1'b1);
    queue_directed();
    wait_idle();

    // The sender keeps offering while the receiver holds off, so the block
    // fills and raises in_stall.
    queue_random(500, 250);
    repeat (60) @(posedge clk);
    hold_armed = 1'b1;
    wait_idle();

    write_mode(1'b0);
    queue_random(400, 150);
    wait_idle();

    write_mode(1'b1);
    queue_random(200, -1);
    wait_idle();

    calm = 1'b1;
    write_mode(1'b0);
    queue_random(250, -1);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && angle_expect.size() == 0) begin
      $display("table_atan2_interpolated_unit test passed");
    end else begin
      $display("table_atan2_interpolated_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ta2_pkg.sv
rtl/ta2_prep.sv
rtl/ta2_div.sv
rtl/ta2_interp.sv
rtl/ta2_obuf.sv
rtl/table_atan2_interpolated_unit.sv
dv/testbench.sv
